>>> rtl/impq_pkg.sv
// ----------------------------------------------------------------------------
// impq_pkg: shared types and constants of the indexed min priority queue
// Holds the request and response structs, the heap entry and the codes.
// ----------------------------------------------------------------------------
package impq_pkg;

  localparam int CAPACITY   = 256;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int POS_W      = $clog2(CAPACITY + 1);
  localparam int HEAP_DEPTH = CAPACITY + 1;
  localparam int PRIO_W     = 32;
  localparam int FUNC_W     = 3;
  localparam int ERR_W      = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL_MIN  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CHANGE   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DECREASE = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_INCREASE = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd6;

  localparam logic [ERR_W-1:0] ERR_OK     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ABSENT = 2'd2;
  localparam logic [ERR_W-1:0] ERR_EMPTY  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [IDX_W-1:0]         entry_index;
    logic signed [PRIO_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]         removed_index;
    logic signed [PRIO_W-1:0] removed_priority;
    logic                     present;
    logic [IDX_W-1:0]         min_index;
    logic signed [PRIO_W-1:0] min_priority;
    logic [POS_W-1:0]         count;
    logic                     empty_res;
    logic [ERR_W-1:0]         error;
  } rsp_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [PRIO_W-1:0] prio;
  } heap_ent_t;

endpackage

>>> rtl/impq_ram.sv
// ----------------------------------------------------------------------------
// impq_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module impq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/impq_cmp.sv
// ----------------------------------------------------------------------------
// impq_cmp: shared priority comparator
// Signed Q16.16 strict greater-than, used by every sift step.
// ----------------------------------------------------------------------------
module impq_cmp
  import impq_pkg::*;
(
  input  logic signed [PRIO_W-1:0] a_i,
  input  logic signed [PRIO_W-1:0] b_i,
  output logic                     gt_o
);

  assign gt_o = (a_i > b_i);

endmodule

>>> rtl/indexed_min_priority_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_priority_queue: indexed binary min-heap with position map
// A sequencer walks the heap one level at a time through a shared comparator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one request item (func,
//   entry_index, priority_req). Output channel out_valid_o / out_stall_i
//   carries one response item per request. An item moves when valid is high
//   and stall is low at a rising edge.
//   A query or a rejected request goes from decode straight to the
//   response. Other requests walk the heap level by level: up through a
//   parent read and compare, down through reads of the left and right
//   child and a compare. Each walk ends with a write of the sifted entry.
//   A removal first reads the removed and the last entry, and re-reads its
//   start slot before it walks down. The time a request takes is set by the
//   heap depth and the single read port of the heap RAM.
//   The block takes one request at a time; in_stall_o is high from accept
//   until the response is loaded into the output register. A new request is
//   taken while an earlier response still waits there.
//   If the receiver stalls, the response holds in the output register and
//   the next request stops at its last step until the register frees.
//   Reset empties the queue and marks every index absent at once through
//   per-index valid bits; no clearing pass is needed.
//   Bad requests (full, duplicate, absent index, empty queue) are flagged in
//   the error field and leave the queue unchanged.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue
  import impq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RD2  = 4'd2;
  localparam logic [3:0] S_RD3  = 4'd3;
  localparam logic [3:0] S_UR   = 4'd4;
  localparam logic [3:0] S_UC   = 4'd5;
  localparam logic [3:0] S_RL   = 4'd6;
  localparam logic [3:0] S_RL2  = 4'd7;
  localparam logic [3:0] S_DL   = 4'd8;
  localparam logic [3:0] S_DR   = 4'd9;
  localparam logic [3:0] S_DC   = 4'd10;
  localparam logic [3:0] S_DX   = 4'd11;
  localparam logic [3:0] S_TOP  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]       state_q, state_d;
  req_t             req_q, req_d;
  heap_ent_t        mv_q, mv_d;      // element being sifted
  heap_ent_t        c_q, c_d;        // chosen child
  heap_ent_t        rem_q, rem_d;
  logic [POS_W-1:0] k_q, k_d;        // hole position
  logic [POS_W-1:0] j_q, j_d;        // chosen child position
  logic [POS_W-1:0] pos0_q, pos0_d;  // start slot of a removal
  logic [POS_W-1:0] count_q, count_d;
  logic [ERR_W-1:0] err_q, err_d;
  logic [CAPACITY-1:0] held_q, held_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  // heap RAM: slot -> {index, priority}
  logic             heap_we;
  logic [POS_W-1:0] heap_raddr;
  heap_ent_t        heap_rdata;
  // position map RAM: index -> slot
  logic [POS_W-1:0] map_rdata;
  logic [IDX_W-1:0] map_raddr;

  heap_ent_t        wr_ent;
  logic [POS_W-1:0] wr_pos;

  logic signed [PRIO_W-1:0] cmp_a, cmp_b;
  logic             cmp_gt;

  logic [POS_W:0]   two_k;
  logic [POS_W:0]   cnt_ext;
  logic [3:0]       up_next;
  logic             held_now;

  impq_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (wr_pos),
    .wdata_i (wr_ent),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  impq_ram #(.WIDTH(POS_W), .DEPTH(CAPACITY)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (wr_ent.idx),
    .wdata_i (wr_pos),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  impq_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .gt_o (cmp_gt)
  );

  assign two_k    = {k_q, 1'b0};
  assign cnt_ext  = {1'b0, count_q};
  assign held_now = held_q[req_q.entry_index];
  assign map_raddr = in_data_i.entry_index;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // where a finished upward walk goes next
  always_comb begin
    case (req_q.func) inside
      FUNC_DEL_MIN, FUNC_DELETE: up_next = S_RL;
      FUNC_CHANGE:               up_next = S_DL;
      default:                   up_next = S_TOP;
    endcase
  end

  // comparator operands per step
  always_comb begin
    cmp_a = mv_q.prio;
    cmp_b = c_q.prio;
    case (state_q)
      S_UC: begin
        cmp_a = heap_rdata.prio;
        cmp_b = mv_q.prio;
      end
      S_DC: begin
        cmp_a = c_q.prio;
        cmp_b = heap_rdata.prio;
      end
      default: begin
        cmp_a = mv_q.prio;
        cmp_b = c_q.prio;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    mv_d        = mv_q;
    c_d         = c_q;
    rem_d       = rem_q;
    k_d         = k_q;
    j_d         = j_q;
    pos0_d      = pos0_q;
    count_d     = count_q;
    err_d       = err_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    heap_we     = 1'b0;
    wr_ent      = mv_q;
    wr_pos      = k_q;
    heap_raddr  = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          rem_d   = '0;
          err_d   = ERR_OK;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        // every 8-bit index lies below the capacity
        state_d = S_TOP;
        unique case (req_q.func) inside
          FUNC_INSERT: begin
            if (held_now || count_q >= POS_W'(CAPACITY)) begin
              err_d = ERR_FULL;
            end else begin
              count_d = count_q + 1'b1;
              k_d     = count_q + 1'b1;
              mv_d    = '{idx: req_q.entry_index, prio: req_q.priority_req};
              held_d[req_q.entry_index] = 1'b1;
              state_d = S_UR;
            end
          end
          FUNC_DEL_MIN: begin
            if (count_q == '0) begin
              err_d = ERR_EMPTY;
            end else begin
              pos0_d     = POS_W'(1);
              heap_raddr = POS_W'(1);
              state_d    = S_RD2;
            end
          end
          FUNC_DELETE: begin
            if (!held_now) begin
              err_d = ERR_ABSENT;
            end else begin
              pos0_d     = map_rdata;
              heap_raddr = map_rdata;
              held_d[req_q.entry_index] = 1'b0;
              state_d    = S_RD2;
            end
          end
          FUNC_CHANGE, FUNC_DECREASE, FUNC_INCREASE: begin
            if (!held_now) begin
              err_d = ERR_ABSENT;
            end else begin
              k_d     = map_rdata;
              mv_d    = '{idx: req_q.entry_index, prio: req_q.priority_req};
              state_d = (req_q.func == FUNC_INCREASE) ? S_DL : S_UR;
            end
          end
          default: begin
            state_d = S_TOP;
          end
        endcase
      end
      S_RD2: begin
        // capture the removed entry, fetch the last one
        rem_d = heap_rdata;
        held_d[heap_rdata.idx] = 1'b0;
        heap_raddr = count_q;
        state_d = S_RD3;
      end
      S_RD3: begin
        count_d = count_q - 1'b1;
        mv_d    = heap_rdata;
        k_d     = pos0_q;
        state_d = (pos0_q < count_q) ? S_UR : S_TOP;
      end
      S_UR: begin
        if (k_q <= POS_W'(1)) begin
          heap_we = 1'b1;
          state_d = up_next;
        end else begin
          heap_raddr = k_q >> 1;
          state_d    = S_UC;
        end
      end
      S_UC: begin
        heap_we = 1'b1;
        if (cmp_gt) begin
          // move the parent down into the hole
          wr_ent  = heap_rdata;
          k_d     = k_q >> 1;
          state_d = S_UR;
        end else begin
          state_d = up_next;
        end
      end
      S_RL: begin
        heap_raddr = pos0_q;
        state_d    = S_RL2;
      end
      S_RL2: begin
        mv_d    = heap_rdata;
        k_d     = pos0_q;
        state_d = S_DL;
      end
      S_DL: begin
        if (two_k > cnt_ext) begin
          heap_we = 1'b1;
          state_d = S_TOP;
        end else begin
          heap_raddr = two_k[POS_W-1:0];
          state_d    = S_DR;
        end
      end
      S_DR: begin
        c_d = heap_rdata;
        j_d = two_k[POS_W-1:0];
        if (two_k < cnt_ext) begin
          heap_raddr = two_k[POS_W-1:0] + 1'b1;
          state_d    = S_DC;
        end else begin
          state_d = S_DX;
        end
      end
      S_DC: begin
        if (cmp_gt) begin
          c_d = heap_rdata;
          j_d = j_q + 1'b1;
        end
        state_d = S_DX;
      end
      S_DX: begin
        heap_we = 1'b1;
        if (cmp_gt) begin
          // move the smaller child up into the hole
          wr_ent  = c_q;
          k_d     = j_q;
          state_d = S_DL;
        end else begin
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        heap_raddr = POS_W'(1);
        state_d    = S_OUT;
      end
      S_OUT: begin
        heap_raddr = POS_W'(1);
        if (!(out_valid_q && out_stall_i)) begin
          out_d.removed_index    = rem_q.idx;
          out_d.removed_priority = rem_q.prio;
          out_d.present          = held_now;
          out_d.min_index        = (count_q != '0) ? heap_rdata.idx : '0;
          out_d.min_priority     = (count_q != '0) ? heap_rdata.prio : '0;
          out_d.count            = count_q;
          out_d.empty_res        = (count_q == '0);
          out_d.error            = err_q;
          out_valid_d            = 1'b1;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    mv_q   <= mv_d;
    c_q    <= c_d;
    rem_q  <= rem_d;
    k_q    <= k_d;
    j_q    <= j_d;
    pos0_q <= pos0_d;
    err_q  <= err_d;
    out_q  <= out_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= POS_W'(CAPACITY))
    else $error("entry count above capacity");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (count_q == $past(count_q)))
    else $error("count changed while idle");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_we |-> (wr_pos != '0 && wr_pos <= count_q))
    else $error("heap write outside the held range");

  a_err_no_removal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error != ERR_OK) |->
      (out_data_o.removed_index == '0 && out_data_o.removed_priority == '0))
    else $error("rejected request reports a removal");

endmodule
